// File: rtl/core/lfu_cache_assert.svh
// ----------------------------------------------------------------------------
// lfu_cache_assert
// assertion macros for the lfu cache
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_ASSERT_SVH
`define LFU_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define LFU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lfu_cache assertion failed");
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lfu_cache assertion failed");
`else
`define LFU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// shared types and constants of the lfu cache
// ----------------------------------------------------------------------------
package lfu_pkg;
	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_UPDATE} lfu_state_t;
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;
	localparam int DATA_BITS = 32;
	localparam int CFG_BITS = 5;
	localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;
	localparam logic [DATA_BITS-1:0] MISS_VALUE = 32'hFFFF_FFFF;
endpackage

// File: rtl/core/lfu_mem.sv
// ----------------------------------------------------------------------------
// lfu_mem
// entry store, one write and one registered read port
// ----------------------------------------------------------------------------
module lfu_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 84,
	parameter int AW = 4
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// File: rtl/core/lfu_cache.sv
// ----------------------------------------------------------------------------
// lfu_cache
// key-value cache with least-frequently-used replacement
// ----------------------------------------------------------------------------
// channel  | handshake             | payload
// command  | start / busy          | opcode, key, value
// result   | result_valid (strobe) | hit, read_value
// config   | cfg_valid / cfg_ready | cfg_data
//
// an item sweeps the entry memory twice through its single read port: a scan
// pass, then the decide state, then an update pass; busy stays high through
// all of them (the update is skipped on a get miss or a dropped put); start is
// taken again once busy is low.
// reset empties the cache at once through the valid flops; no clearing pass.
// the result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`include "lfu_cache_assert.svh"

module lfu_cache import lfu_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 opcode,
	input  logic [DATA_BITS-1:0] key,
	input  logic signed [DATA_BITS-1:0] value,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_BITS-1:0]  cfg_data,
	output logic                 result_valid,
	output logic                 hit,
	output logic signed [DATA_BITS-1:0] read_value
);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int NW = $clog2(CAPACITY + 1);
	localparam int WW = 2 * DATA_BITS + COUNT_BITS + IW;
	localparam int CNT_LO = IW;
	localparam int VAL_LO = IW + COUNT_BITS;
	localparam int KEY_LO = VAL_LO + DATA_BITS;
	localparam logic [NW-1:0] DEPTH_N = NW'(CAPACITY);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	lfu_state_t state_q, state_d;
	logic [CFG_BITS-1:0] cap_q;
	logic [NW-1:0] cap_eff;
	logic [CAPACITY-1:0] valid_q;
	logic [NW-1:0] addr_q;
	logic rd_vld_s1;
	logic [IW-1:0] idx_s1;
	logic rd_en, wr_en, cfg_wr, accept, sweep_done, go_upd;
	logic [WW-1:0] rd_data, wr_data;
	logic [DATA_BITS-1:0] d_key, d_val;
	logic [COUNT_BITS-1:0] d_cnt;
	logic [IW-1:0] d_rec;
	logic d_valid;

	logic op_q;
	logic [DATA_BITS-1:0] key_q, val_q, hval_q;
	logic found_q, vic_found_q, free_found_q, dec_q;
	logic [IW-1:0] tgt_q, hrec_q, vic_q, vrec_q, free_q, old_q;
	logic [COUNT_BITS-1:0] hcnt_q, vcnt_q;
	logic [NW-1:0] occ_q;
	logic [WW-1:0] new_q;

	logic [IW-1:0] tgt_d, old_d;
	logic dec_d, ins_free;
	logic [WW-1:0] new_d;
	logic [COUNT_BITS-1:0] hcnt_inc;

	logic res_vld_q, res_hit_q;
	logic [DATA_BITS-1:0] res_val_q;

	assign cap_eff = (32'(cap_q) > 32'(CAPACITY)) ? DEPTH_N : NW'(cap_q);
	assign accept = start && !busy;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign sweep_done = (addr_q == DEPTH_N) && !rd_vld_s1;
	assign d_key = rd_data[KEY_LO +: DATA_BITS];
	assign d_val = rd_data[VAL_LO +: DATA_BITS];
	assign d_cnt = rd_data[CNT_LO +: COUNT_BITS];
	assign d_rec = rd_data[IW-1:0];
	assign d_valid = valid_q[idx_s1];
	assign hcnt_inc = (hcnt_q == CNT_MAX) ? hcnt_q : hcnt_q + CNT_ONE;
	assign go_upd = (op_q == OP_GET) ? found_q : (cap_eff != '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_SCAN;
			ST_SCAN:   if (sweep_done) state_d = ST_DECIDE;
			ST_DECIDE: state_d = go_upd ? ST_UPDATE : ST_IDLE;
			ST_UPDATE: if (sweep_done) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != ST_IDLE);
		cfg_ready = (state_q == ST_IDLE);
		rd_en = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && (addr_q < DEPTH_N);
		wr_en = 1'b0;
		wr_data = new_q;
		if ((state_q == ST_UPDATE) && rd_vld_s1) begin
			if (idx_s1 == tgt_q) begin
				wr_en = 1'b1;
			end else if (d_valid && dec_q && (d_rec > old_q)) begin
				wr_en = 1'b1;
				wr_data = {rd_data[WW-1:IW], d_rec - IW'(1)};
			end
		end
	end

	// decision on the scan summary
	always_comb begin
		tgt_d = tgt_q;
		old_d = hrec_q;
		dec_d = 1'b1;
		ins_free = 1'b0;
		new_d = {key_q, hval_q, hcnt_inc, IW'(occ_q - NW'(1))};
		if (op_q == OP_PUT) begin
			if (found_q) begin
				new_d = {key_q, val_q, hcnt_inc, IW'(occ_q - NW'(1))};
			end else if (occ_q >= cap_eff) begin
				tgt_d = vic_q;
				old_d = vrec_q;
				new_d = {key_q, val_q, CNT_ONE, IW'(occ_q - NW'(1))};
			end else begin
				tgt_d = free_q;
				dec_d = 1'b0;
				ins_free = 1'b1;
				new_d = {key_q, val_q, CNT_ONE, IW'(occ_q)};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q <= CAP_RESET;
			valid_q <= '0;
			addr_q <= '0;
			rd_vld_s1 <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= rd_en;
			res_vld_q <= (state_q == ST_DECIDE) && (op_q == OP_GET);
			if (cfg_wr) begin
				cap_q <= cfg_data;
				valid_q <= '0;
			end
			if (accept || (state_q == ST_DECIDE)) begin
				addr_q <= '0;
			end else if (rd_en) begin
				addr_q <= addr_q + NW'(1);
			end
			if ((state_q == ST_DECIDE) && go_upd && ins_free) begin
				valid_q[free_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q[IW-1:0];
		if (accept) begin
			op_q <= opcode;
			key_q <= key;
			val_q <= value;
			found_q <= 1'b0;
			vic_found_q <= 1'b0;
			free_found_q <= 1'b0;
			occ_q <= '0;
		end
		if ((state_q == ST_SCAN) && rd_vld_s1) begin
			if (d_valid) begin
				occ_q <= occ_q + NW'(1);
				if (d_key == key_q) begin
					found_q <= 1'b1;
					tgt_q <= idx_s1;
					hval_q <= d_val;
					hcnt_q <= d_cnt;
					hrec_q <= d_rec;
				end
				if (!vic_found_q || (d_cnt < vcnt_q) ||
				    ((d_cnt == vcnt_q) && (d_rec < vrec_q))) begin
					vic_found_q <= 1'b1;
					vic_q <= idx_s1;
					vcnt_q <= d_cnt;
					vrec_q <= d_rec;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_q <= idx_s1;
			end
		end
		if (state_q == ST_DECIDE) begin
			tgt_q <= tgt_d;
			old_q <= old_d;
			dec_q <= dec_d;
			new_q <= new_d;
			res_hit_q <= found_q;
			res_val_q <= found_q ? hval_q : MISS_VALUE;
		end
	end

	lfu_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(WW),
		.AW(IW)
	) u_mem (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(addr_q[IW-1:0]),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(idx_s1),
		.wr_data(wr_data)
	);

	assign result_valid = res_vld_q;
	assign hit = res_hit_q;
	assign read_value = res_val_q;

	`LFU_ASSERT_NEXT(a_get_gives_result, clk, arst_n, (state_q == ST_DECIDE) && (op_q == OP_GET), result_valid)
	`LFU_ASSERT_SAME(a_miss_value, clk, arst_n, result_valid && !hit, read_value == MISS_VALUE)
	`LFU_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	`LFU_ASSERT_NEXT(a_cfg_flush, clk, arst_n, cfg_wr, valid_q == '0)
endmodule

// File: tb/sv/lfu_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_tb
// checks lookups, inserts, updates and lfu eviction of the lfu cache
// ----------------------------------------------------------------------------
// a shadow cache in the testbench predicts every get result; directed tests
// cover capacity extremes, ties, count order and flushing, then random
// traffic over small key pools exercises hits, updates and eviction.
// ----------------------------------------------------------------------------
module lfu_cache_tb;
	import lfu_pkg::*;

	localparam int SLOTS = 16;
	localparam int CNT_BITS = 16;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic opcode = OP_GET;
	logic [DATA_BITS-1:0] key = '0;
	logic signed [DATA_BITS-1:0] value = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_BITS-1:0] cfg_data = '0;
	logic result_valid;
	logic hit;
	logic signed [DATA_BITS-1:0] read_value;

	typedef struct packed {
		logic hit;
		logic [DATA_BITS-1:0] data;
	} lookup_t;

	lookup_t lookup_q[$];
	bit sh_valid[SLOTS];
	logic [DATA_BITS-1:0] sh_key[SLOTS];
	logic [DATA_BITS-1:0] sh_data[SLOTS];
	logic [CNT_BITS-1:0] sh_count[SLOTS];
	int unsigned sh_rank[SLOTS];
	int unsigned sh_cap;
	int mismatches = 0;
	int gets_checked = 0;
	int hits_seen = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	bit timed_out = 0;

	lfu_cache DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.key(key), .value(value), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .result_valid(result_valid), .hit(hit),
		.read_value(read_value)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int unsigned live_entries();
		int unsigned n = 0;
		for (int i = 0; i < SLOTS; i++) if (sh_valid[i]) n++;
		return n;
	endfunction

	function automatic void flush_shadow();
		for (int i = 0; i < SLOTS; i++) sh_valid[i] = 0;
	endfunction

	function automatic void retire_rank(int s);
		for (int i = 0; i < SLOTS; i++)
			if (i != s && sh_valid[i] && sh_rank[i] > sh_rank[s]) sh_rank[i]--;
	endfunction

	function automatic void touch_entry(int s);
		if (sh_count[s] != {CNT_BITS{1'b1}}) sh_count[s]++;
		retire_rank(s);
		sh_rank[s] = live_entries() - 1;
	endfunction

	function automatic void predict_access(logic op, logic [DATA_BITS-1:0] k,
			logic [DATA_BITS-1:0] v);
		int s = -1;
		int victim = -1;
		int unsigned cap;
		cap = (sh_cap > SLOTS) ? SLOTS : sh_cap;
		for (int i = 0; i < SLOTS; i++)
			if (s < 0 && sh_valid[i] && sh_key[i] == k) s = i;
		if (op == OP_GET) begin
			if (s >= 0) begin
				lookup_q.push_back('{1'b1, sh_data[s]});
				touch_entry(s);
			end else begin
				lookup_q.push_back('{1'b0, MISS_VALUE});
			end
			return;
		end
		if (cap == 0) return;
		if (s >= 0) begin
			sh_data[s] = v;
			touch_entry(s);
			return;
		end
		if (live_entries() >= cap) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!sh_valid[i]) continue;
				if (victim < 0 || sh_count[i] < sh_count[victim] ||
						(sh_count[i] == sh_count[victim] && sh_rank[i] < sh_rank[victim]))
					victim = i;
			end
			if (victim >= 0) begin
				retire_rank(victim);
				sh_valid[victim] = 0;
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (!sh_valid[i]) begin
				sh_valid[i] = 1;
				sh_key[i] = k;
				sh_data[i] = v;
				sh_count[i] = 1;
				sh_rank[i] = live_entries() - 1;
				break;
			end
		end
	endfunction

	// sender with a gap set by the caller; bursts come from the caller's gap choice
	task automatic send_access(logic op, logic [DATA_BITS-1:0] k,
			logic [DATA_BITS-1:0] v, int gap = 0);
		repeat (gap + 1) @(posedge clk);
		start <= 1'b1;
		opcode <= op;
		key <= k;
		value <= v;
		do @(posedge clk); while (busy);
		predict_access(op, k, v);
		items_sent++;
		start <= 1'b0;
	endtask

	task automatic drain_results();
		while (lookup_q.size() != 0) @(posedge clk);
		repeat (2 * SLOTS + 8) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CFG_BITS-1:0] c);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sh_cap = c;
		flush_shadow();
	endtask

	function automatic int rand_gap();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
	endfunction

	task automatic test_extremes();
		send_access(OP_GET, 32'h0, 32'h0);
		send_access(OP_PUT, 32'h0, 32'h8000_0000);
		send_access(OP_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_access(OP_PUT, 32'h5555_5555, 32'hFFFF_FFFF);
		send_access(OP_GET, 32'h0, 32'h1234);
		send_access(OP_GET, 32'hFFFF_FFFF, 32'h0);
		send_access(OP_GET, 32'h5555_5555, 32'h0);
		send_access(OP_GET, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
		send_access(OP_PUT, 32'h0, 32'h1);
		send_access(OP_GET, 32'h0, 32'h0);
	endtask

	task automatic test_eviction_ties();
		write_capacity(5'd2);
		send_access(OP_PUT, 32'd10, 32'd100);
		send_access(OP_PUT, 32'd11, 32'd110);
		send_access(OP_PUT, 32'd12, 32'd120);
		send_access(OP_GET, 32'd10, 32'd0);
		send_access(OP_GET, 32'd11, 32'd0);
		send_access(OP_GET, 32'd11, 32'd0);
		send_access(OP_PUT, 32'd13, 32'd130);
		send_access(OP_GET, 32'd12, 32'd0);
		send_access(OP_GET, 32'd13, 32'd0);
	endtask

	task automatic test_capacity_settings();
		write_capacity(5'd0);
		send_access(OP_PUT, 32'd1, 32'd1);
		send_access(OP_GET, 32'd1, 32'd0);
		write_capacity(5'd1);
		send_access(OP_PUT, 32'd1, 32'd5);
		send_access(OP_PUT, 32'd2, 32'd6);
		send_access(OP_GET, 32'd1, 32'd0);
		send_access(OP_GET, 32'd2, 32'd0);
		write_capacity(5'd31);
		for (int i = 0; i < 18; i++) send_access(OP_PUT, i, i + 1000);
		for (int i = 0; i < 18; i++) send_access(OP_GET, i, 0);
		// flush: previously stored key must miss
		write_capacity(5'd16);
		send_access(OP_GET, 32'd17, 32'd0);
	endtask

	task automatic test_random(int n, logic [CFG_BITS-1:0] c, int pool);
		logic [DATA_BITS-1:0] k;
		write_capacity(c);
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, pool - 1);
			if ($urandom_range(0, 9) == 0) k = k ^ 32'hFFFF_0000;
			send_access($urandom_range(0, 1) ? OP_PUT : OP_GET, k, $urandom(), rand_gap());
			if (i == n / 2) drain_results();
		end
	endtask

	always @(posedge clk) begin
		lookup_t exp_r;
		if (start && !busy || result_valid || cfg_valid && cfg_ready) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (arst_n && result_valid) begin
			if (lookup_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result hit=%0b data=%h", hit, read_value);
			end else begin
				exp_r = lookup_q.pop_front();
				gets_checked++;
				if (hit) hits_seen++;
				if (hit !== exp_r.hit || read_value !== exp_r.data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected hit=%0b data=%h, got hit=%0b data=%h",
							exp_r.hit, exp_r.data, hit, read_value);
				end
			end
		end
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("watchdog expired after %0d idle cycles", idle_cycles);
		$display("status: fail");
		$finish;
	end

	initial begin
		sh_cap = CAP_RESET;
		flush_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_eviction_ties();
		test_capacity_settings();
		test_random(500, 5'd16, 24);
		test_random(400, 5'd4, 8);
		test_random(400, 5'd9, 14);
		test_random(500, 5'd16, 40);
		drain_results();
		if (lookup_q.size() != 0) mismatches += lookup_q.size();
		$display("sent %0d items, checked %0d lookups (%0d hits) over capacities 0..31",
			items_sent, gets_checked, hits_seen);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end
endmodule
